[hdl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge once reset is released
`define GIA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked on every clock edge once reset is released
`define GIA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[hdl/gia_pkg.sv]
package gia_pkg;

   localparam int MAX_DIM     = 64;
   localparam int QUEUE_DEPTH = 4096;

   localparam int COORD_W   = $clog2(MAX_DIM);
   localparam int DIM_EFF_W = COORD_W + 1;
   localparam int ADDR_W    = 2 * COORD_W;
   localparam int CELLS     = 1 << ADDR_W;
   localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
   localparam int TAIL_W    = $clog2(QUEUE_DEPTH + 1);

   // fixed field widths
   localparam int POS_W     = 6;
   localparam int CELL_W    = 8;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int AREA_W    = 13;
   localparam int AREA_MAX  = 8191;

   localparam logic [CFG_W-1:0] GRID_ROWS_RST = 7'd10;
   localparam logic [CFG_W-1:0] GRID_COLS_RST = 7'd10;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'b1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      DIR_EAST,
      DIR_SOUTH,
      DIR_WEST,
      DIR_NORTH
   } gia_dir_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP,
      ST_FETCH,
      ST_PROBE,
      ST_TEST,
      ST_CLEAN
   } gia_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              land_we;
      logic              land_wd;
      logic              vis_we;
      logic              vis_wd;
   } map_req_type;

   typedef struct packed {
      logic              we;
      logic [QIDX_W-1:0] waddr;
      logic [ADDR_W-1:0] wdata;
      logic [QIDX_W-1:0] raddr;
   } queue_req_type;

   typedef struct packed {
      logic              ok;
      logic [ADDR_W-1:0] addr;
   } nbr_type;

endpackage

[hdl/grid_island_area_bfs.sv]
// island area by breadth-first flood fill over a 64 x 64 land map
// map write: no result; query with a bad start: result strobe the next cycle
// good query: per reached cell a pop and a fetch, then four neighbour probes through the
// shared step unit, each in-bounds probe followed by a map test; then a visited clean-up
// pass while busy stays high; results cannot be stalled by the receiver
// reset (synchronous, active high) starts a clearing pass of both maps
`include "assert_macros.svh"

module grid_island_area_bfs (
   input  logic                         clock,
   input  logic                         reset,
   // request beat
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [gia_pkg::POS_W-1:0]    req_row,
   input  logic [gia_pkg::POS_W-1:0]    req_col,
   input  logic [gia_pkg::CELL_W-1:0]   req_cell_value,
   // result beat
   output logic                         rsp_valid,
   output logic [gia_pkg::AREA_W-1:0]   rsp_area,
   output logic                         rsp_bad_start,
   // register writes
   input  logic                         csr_we,
   input  logic [gia_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gia_pkg::CFG_W-1:0]    csr_wdata
);
   import gia_pkg::*;

   // sequencer state
   gia_state_type      state_ff, state_in;
   gia_dir_type        dir_ff, dir_in;
   logic [TAIL_W-1:0]  head_ff, head_in;
   logic [TAIL_W-1:0]  tail_ff, tail_in;
   logic [TAIL_W-1:0]  clean_idx_ff, clean_idx_in;
   logic               clean_vld_ff, clean_vld_in;
   logic [ADDR_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [ADDR_W-1:0]  probe_addr_ff, probe_addr_in;

   // configuration
   logic [CFG_W-1:0]   rows_ff;
   logic [CFG_W-1:0]   cols_ff;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]  rsp_area_ff, rsp_area_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [DIM_EFF_W-1:0] rows_eff;
   logic [DIM_EFF_W-1:0] cols_eff;
   logic                 req_fire;
   logic                 req_bad;
   logic [ADDR_W-1:0]    req_addr;

   map_req_type        map_req;
   queue_req_type      q_req;
   logic               land_q;
   logic               vis_q;
   logic [ADDR_W-1:0]  q_rdata;
   nbr_type            nbr;

   // shared neighbour step unit, used four times per dequeued cell
   gia_nbr_unit u_nbr (
      .cur_row  (cur_row_ff),
      .cur_col  (cur_col_ff),
      .dir      (dir_ff),
      .rows_eff (rows_eff),
      .cols_eff (cols_eff),
      .nbr      (nbr)
   );

   // land and visited bit maps, registered read
   gia_maps u_maps (
      .clock  (clock),
      .req    (map_req),
      .land_q (land_q),
      .vis_q  (vis_q)
   );

   // coordinate queue, registered read
   gia_queue u_queue (
      .clock (clock),
      .req   (q_req),
      .rdata (q_rdata)
   );

   // grid size registers above the store size act as the store size
   assign rows_eff = (32'(rows_ff) > MAX_DIM) ? DIM_EFF_W'(MAX_DIM) : DIM_EFF_W'(rows_ff);
   assign cols_eff = (32'(cols_ff) > MAX_DIM) ? DIM_EFF_W'(MAX_DIM) : DIM_EFF_W'(cols_ff);

   assign busy     = state_ff != ST_IDLE;
   assign req_fire = start && !busy;
   assign req_bad  = (32'(req_row) >= 32'(rows_eff)) || (32'(req_col) >= 32'(cols_eff));
   assign req_addr = {COORD_W'(req_row), COORD_W'(req_col)};

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_area      = rsp_area_ff;
   assign rsp_bad_start = rsp_bad_ff;

   // register write port
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= GRID_ROWS_RST;
         cols_ff <= GRID_COLS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GRID_ROWS: rows_ff <= csr_wdata;
            REG_GRID_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         dir_ff       <= DIR_EAST;
         head_ff      <= '0;
         tail_ff      <= '0;
         clean_idx_ff <= '0;
         clean_vld_ff <= 1'b0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         clean_idx_ff <= clean_idx_in;
         clean_vld_ff <= clean_vld_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      probe_addr_ff <= probe_addr_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      clean_idx_in  = clean_idx_ff;
      clean_vld_in  = 1'b0;
      init_cnt_in   = init_cnt_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      probe_addr_in = probe_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_area_in   = rsp_area_ff;
      rsp_bad_in    = rsp_bad_ff;

      map_req       = '0;
      map_req.addr  = req_addr;
      q_req         = '0;
      q_req.raddr   = head_ff[QIDX_W-1:0];

      unique case (state_ff)
         // wipe both maps one cell a cycle
         ST_INIT: begin
            map_req.addr    = init_cnt_ff;
            map_req.land_we = 1'b1;
            map_req.vis_we  = 1'b1;
            init_cnt_in     = init_cnt_ff + 1'b1;
            if (init_cnt_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_WRITE) begin
                  // writes beyond the store are dropped
                  map_req.land_we = (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
                  map_req.land_wd = req_cell_value != '0;
               end else if (req_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_area_in  = '0;
                  rsp_bad_in   = 1'b1;
               end else begin
                  // seed the queue with the start cell, land or not
                  map_req.vis_we = 1'b1;
                  map_req.vis_wd = 1'b1;
                  q_req.we       = 1'b1;
                  q_req.waddr    = '0;
                  q_req.wdata    = req_addr;
                  head_in        = '0;
                  tail_in        = TAIL_W'(1);
                  state_in       = ST_POP;
               end
            end
         end

         ST_POP: begin
            if (head_ff == tail_ff) begin
               // flood done, area is the number of cells ever queued
               rsp_valid_in = 1'b1;
               rsp_bad_in   = 1'b0;
               rsp_area_in  = (32'(tail_ff) > AREA_MAX) ? AREA_W'(AREA_MAX)
                                                         : AREA_W'(tail_ff);
               clean_idx_in = '0;
               state_in     = ST_CLEAN;
            end else begin
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            cur_row_in = q_rdata[ADDR_W-1:COORD_W];
            cur_col_in = q_rdata[COORD_W-1:0];
            dir_in     = DIR_EAST;
            head_in    = head_ff + 1'b1;
            state_in   = ST_PROBE;
         end

         ST_PROBE: begin
            map_req.addr  = nbr.addr;
            probe_addr_in = nbr.addr;
            if (nbr.ok) begin
               state_in = ST_TEST;
            end else if (dir_ff == DIR_NORTH) begin
               state_in = ST_POP;
            end else begin
               dir_in = gia_dir_type'(dir_ff + 1'b1);
            end
         end

         ST_TEST: begin
            map_req.addr = probe_addr_ff;
            if (land_q && !vis_q && (32'(tail_ff) < QUEUE_DEPTH)) begin
               map_req.vis_we = 1'b1;
               map_req.vis_wd = 1'b1;
               q_req.we       = 1'b1;
               q_req.waddr    = tail_ff[QIDX_W-1:0];
               q_req.wdata    = probe_addr_ff;
               tail_in        = tail_ff + 1'b1;
            end
            if (dir_ff == DIR_NORTH) begin
               state_in = ST_POP;
            end else begin
               dir_in   = gia_dir_type'(dir_ff + 1'b1);
               state_in = ST_PROBE;
            end
         end

         // the queue holds exactly the visited cells: read each back and clear it
         ST_CLEAN: begin
            q_req.raddr  = clean_idx_ff[QIDX_W-1:0];
            map_req.addr = q_rdata;
            if (clean_vld_ff) begin
               map_req.vis_we = 1'b1;
               map_req.vis_wd = 1'b0;
            end
            if (clean_idx_ff != tail_ff) begin
               clean_vld_in = 1'b1;
               clean_idx_in = clean_idx_ff + 1'b1;
            end else if (!clean_vld_ff) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_INIT;
      endcase
   end

   `GIA_ASSERT(a_head_le_tail, head_ff <= tail_ff, "queue head passed tail")
   `GIA_ASSERT(a_tail_in_range, 32'(tail_ff) <= QUEUE_DEPTH, "queue tail beyond depth")
   `GIA_ASSERT_IMP(a_flood_then_clean, rsp_valid_ff && !rsp_bad_ff,
      state_ff == ST_CLEAN, "flood result without clean-up pass")
   `GIA_ASSERT_IMP(a_bad_zero_area, rsp_valid_ff && rsp_bad_ff,
      rsp_area_ff == '0, "bad start with nonzero area")

endmodule

[hdl/gia_nbr_unit.sv]
module gia_nbr_unit (
   input  logic [gia_pkg::COORD_W-1:0]   cur_row,
   input  logic [gia_pkg::COORD_W-1:0]   cur_col,
   input  gia_pkg::gia_dir_type          dir,
   input  logic [gia_pkg::DIM_EFF_W-1:0] rows_eff,
   input  logic [gia_pkg::DIM_EFF_W-1:0] cols_eff,
   output gia_pkg::nbr_type              nbr
);
   import gia_pkg::*;

   logic [DIM_EFF_W-1:0] row_ext;
   logic [DIM_EFF_W-1:0] col_ext;

   assign row_ext = {1'b0, cur_row};
   assign col_ext = {1'b0, cur_col};

   // one step in the chosen direction plus the bounds check
   always_comb begin
      nbr = '0;
      unique case (dir)
         DIR_EAST: begin
            nbr.ok   = (col_ext + 1'b1) < cols_eff;
            nbr.addr = {cur_row, cur_col + 1'b1};
         end
         DIR_SOUTH: begin
            nbr.ok   = (row_ext + 1'b1) < rows_eff;
            nbr.addr = {cur_row + 1'b1, cur_col};
         end
         DIR_WEST: begin
            nbr.ok   = cur_col != '0;
            nbr.addr = {cur_row, cur_col - 1'b1};
         end
         DIR_NORTH: begin
            nbr.ok   = cur_row != '0;
            nbr.addr = {cur_row - 1'b1, cur_col};
         end
         default: nbr = '0;
      endcase
   end

endmodule

[hdl/gia_maps.sv]
module gia_maps (
   input  logic                 clock,
   input  gia_pkg::map_req_type req,
   output logic                 land_q,
   output logic                 vis_q
);
   import gia_pkg::*;

   logic land_mem [CELLS];
   logic vis_mem  [CELLS];

   always_ff @(posedge clock) begin
      if (req.land_we) begin
         land_mem[req.addr] <= req.land_wd;
      end
      if (req.vis_we) begin
         vis_mem[req.addr] <= req.vis_wd;
      end
      land_q <= land_mem[req.addr];
      vis_q  <= vis_mem[req.addr];
   end

endmodule

[hdl/gia_queue.sv]
module gia_queue (
   input  logic                          clock,
   input  gia_pkg::queue_req_type        req,
   output logic [gia_pkg::ADDR_W-1:0]    rdata
);
   import gia_pkg::*;

   logic [ADDR_W-1:0] q_mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (req.we) begin
         q_mem[req.waddr] <= req.wdata;
      end
      rdata <= q_mem[req.raddr];
   end

endmodule
